// ===== rtl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the IR pulse-distance frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

	// Field widths of the item channels
	localparam int PAYLOAD_W = 64;
	localparam int COUNT_W   = 7;
	localparam int REPEAT_W  = 16;
	localparam int TICK_W    = 8;

	// Largest supported frame, in bits
	localparam int MAX_BITS_DEF = 64;

	// Configuration register file
	localparam int NUM_REGS  = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HDR_MARK   = 3'd0,
		REG_HDR_SPACE  = 3'd1,
		REG_BIT_MARK   = 3'd2,
		REG_ONE_SPACE  = 3'd3,
		REG_ZERO_SPACE = 3'd4,
		REG_GAP        = 3'd5
	} reg_idx_t;

	typedef logic [TICK_W-1:0] tick_t;

	localparam tick_t CFG_RESET [NUM_REGS] = '{
		8'd43, 8'd43, 8'd5, 8'd17, 8'd5, 8'd53
	};

	// Frame segment sequencer, one-hot
	typedef enum logic [6:0] {
		SEG_IDLE      = 7'b0000001,
		SEG_HDR_MARK  = 7'b0000010,
		SEG_HDR_SPACE = 7'b0000100,
		SEG_BIT_MARK  = 7'b0001000,
		SEG_BIT_SPACE = 7'b0010000,
		SEG_FOOT_MARK = 7'b0100000,
		SEG_GAP       = 7'b1000000
	} seg_t;

endpackage

`default_nettype wire

// ===== rtl/ir_pulse_distance_frame_transmitter_top.sv =====
// A result word is registered: it becomes valid in the cycle after its input word is taken.
// Throughput: one word per cycle while out_ready takes each result; the segment sequencer and tick counter
// update in a single pass between the input handshake and the result register.
// The result register frees the input side whenever its word is taken or empty.
// Reset: sequencer idle, timing registers at their defaults (43, 43, 5, 17,
// 5, 53 ticks), no result pending.
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_transmitter_top
// Envelope generator for pulse-distance IR frames with inverted repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_frame_transmitter_top #(
	parameter int MAX_BITS = irpd_pkg::MAX_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input word channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           action,
	input  wire logic [irpd_pkg::PAYLOAD_W-1:0] payload,
	input  wire logic [irpd_pkg::COUNT_W-1:0]   bit_count,
	input  wire logic [irpd_pkg::REPEAT_W-1:0]  repeat_count,
	// Result word channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                led_on,
	output logic                                busy_res,
	output logic                                start_rejected,
	// Configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [irpd_pkg::TICK_W-1:0]    cfg_data
);

	import irpd_pkg::*;

	localparam int BIT_CNT_W = $clog2(MAX_BITS + 1);
	localparam int BIT_IDX_W = $clog2(MAX_BITS);
	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BITS);

	// Timing registers
	tick_t cfg_q [NUM_REGS];

	// Sequencer state
	seg_t                   seg_q,    seg_n;
	tick_t                  ticks_q,  ticks_n;
	logic [BIT_CNT_W-1:0]   pos_q,    pos_n;
	logic                   inv_q,    inv_n;
	logic [REPEAT_W-1:0]    rounds_q, rounds_n;
	logic [MAX_BITS-1:0]    frame_q,  frame_n;
	logic [BIT_CNT_W-1:0]   bits_q,   bits_n;

	// Result register
	logic out_valid_q, led_q, busy_q, rej_q;

	logic                 in_acc;
	logic                 busy;
	logic                 bad_count;
	logic [BIT_CNT_W-1:0] bit_sel;
	logic                 cur_bit;
	logic [BIT_CNT_W-1:0] pos_inc;
	logic                 enter_en;
	seg_t                 enter_kind;
	tick_t                enter_len;
	logic                 led_n, rej_n;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign busy      = (seg_q != SEG_IDLE);
	assign bad_count = (bit_count[2:0] != 3'd0) || (bit_count > MAX_CNT);

	// Pick the data bit sent in the current bit slot, MSB first
	assign bit_sel = BIT_CNT_W'(bits_q - pos_q - 1'b1);
	assign cur_bit = frame_q[bit_sel[BIT_IDX_W-1:0]] ^ inv_q;
	assign pos_inc = BIT_CNT_W'(pos_q + 1'b1);

	// Advance the sequencer for one accepted word
	always_comb begin
		seg_n      = seg_q;
		ticks_n    = ticks_q;
		pos_n      = pos_q;
		inv_n      = inv_q;
		rounds_n   = rounds_q;
		frame_n    = frame_q;
		bits_n     = bits_q;
		led_n      = 1'b0;
		rej_n      = 1'b0;
		enter_en   = 1'b0;
		enter_kind = SEG_IDLE;
		if (action) begin
			if (busy || bad_count) begin
				rej_n = 1'b1;
			end else begin
				frame_n    = payload[MAX_BITS-1:0];
				bits_n     = bit_count[BIT_CNT_W-1:0];
				rounds_n   = repeat_count;
				inv_n      = 1'b0;
				pos_n      = '0;
				enter_en   = 1'b1;
				enter_kind = SEG_HDR_MARK;
			end
		end else if (busy) begin
			led_n = (seg_q == SEG_HDR_MARK) || (seg_q == SEG_BIT_MARK) ||
				(seg_q == SEG_FOOT_MARK);
			if (ticks_q <= tick_t'(1)) begin
				unique case (seg_q)
					SEG_HDR_MARK: begin
						enter_en   = 1'b1;
						enter_kind = SEG_HDR_SPACE;
					end
					SEG_HDR_SPACE: begin
						pos_n      = '0;
						enter_en   = 1'b1;
						enter_kind = (bits_q != '0) ? SEG_BIT_MARK : SEG_FOOT_MARK;
					end
					SEG_BIT_MARK: begin
						enter_en   = 1'b1;
						enter_kind = SEG_BIT_SPACE;
					end
					SEG_BIT_SPACE: begin
						pos_n      = pos_inc;
						enter_en   = 1'b1;
						enter_kind = (pos_inc < bits_q) ? SEG_BIT_MARK : SEG_FOOT_MARK;
					end
					SEG_FOOT_MARK: begin
						enter_en   = 1'b1;
						enter_kind = SEG_GAP;
					end
					SEG_GAP: begin
						if (!inv_q) begin
							inv_n      = 1'b1;
							enter_en   = 1'b1;
							enter_kind = SEG_HDR_MARK;
						end else if (rounds_q != '0) begin
							rounds_n   = REPEAT_W'(rounds_q - 1'b1);
							inv_n      = 1'b0;
							enter_en   = 1'b1;
							enter_kind = SEG_HDR_MARK;
						end else begin
							inv_n   = 1'b0;
							pos_n   = '0;
							ticks_n = '0;
							seg_n   = SEG_IDLE;
						end
					end
					default: begin
						seg_n   = SEG_IDLE;
						ticks_n = '0;
					end
				endcase
			end else begin
				ticks_n = tick_t'(ticks_q - 1'b1);
			end
		end

		// Load the length of a newly entered segment
		unique case (enter_kind)
			SEG_HDR_MARK:  enter_len = cfg_q[REG_HDR_MARK];
			SEG_HDR_SPACE: enter_len = cfg_q[REG_HDR_SPACE];
			SEG_BIT_MARK:  enter_len = cfg_q[REG_BIT_MARK];
			SEG_BIT_SPACE: enter_len = cur_bit ? cfg_q[REG_ONE_SPACE] : cfg_q[REG_ZERO_SPACE];
			SEG_FOOT_MARK: enter_len = cfg_q[REG_BIT_MARK];
			SEG_GAP:       enter_len = cfg_q[REG_GAP];
			default:       enter_len = '0;
		endcase
		if (enter_en) begin
			seg_n   = enter_kind;
			ticks_n = enter_len;
		end
	end

	// Write timing registers; ignore indexes past the end of the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					cfg_q[i] <= cfg_data;
				end
			end
		end
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= SEG_IDLE;
			ticks_q  <= '0;
			pos_q    <= '0;
			inv_q    <= 1'b0;
			rounds_q <= '0;
		end else if (in_acc) begin
			seg_q    <= seg_n;
			ticks_q  <= ticks_n;
			pos_q    <= pos_n;
			inv_q    <= inv_n;
			rounds_q <= rounds_n;
		end
	end

	// Frame contents, loaded on an accepted start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			bits_q  <= '0;
		end else if (in_acc) begin
			frame_q <= frame_n;
			bits_q  <= bits_n;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			led_q  <= led_n;
			busy_q <= (seg_n != SEG_IDLE);
			rej_q  <= rej_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign led_on         = led_q;
	assign busy_res       = busy_q;
	assign start_rejected = rej_q;

	// A result never shows a lit LED together with a refused start
	a_led_rej_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(led_q && rej_q))
		else $error("led_on and start_rejected both set");

	// A running tick count above one steps down by one on each accepted non-start word
	a_tick_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !action && busy && (ticks_q > tick_t'(1))) |=>
		(ticks_q == tick_t'($past(ticks_q) - 1'b1)))
		else $error("tick counter did not decrement");

	// Bit position never runs past the frame length while active
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pos_q <= bits_q))
		else $error("bit position beyond frame length");

	// A refused start leaves the sequencer untouched
	a_rej_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action && busy) |=> ($stable(seg_q) && $stable(ticks_q) &&
		$stable(pos_q) && $stable(rounds_q)))
		else $error("refused start changed sequencer state");

endmodule

`default_nettype wire
